@@ rtl/core/onewire_temperature_reader_assert.svh @@
// assertion macros for the one-wire temperature reader
`ifndef ONEWIRE_TEMPERATURE_READER_ASSERT_SVH
`define ONEWIRE_TEMPERATURE_READER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define OWTR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// next-cycle implication, disabled during reset
`define OWTR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define OWTR_ASSERT_IMP(label, clk, rst, ante, cons)
`define OWTR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/owtr_pkg.sv @@
// shared types, register indexes and constants of the one-wire temperature reader
`default_nettype none

package owtr_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 20;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // register indexes on the config channel
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_TIMEOUT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_RECOVER    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT             = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE          = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE           = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CONVERT_WAIT     = 3'd6;

  // input beat kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  // command sequence steps
  localparam logic [2:0] STEP_RESET1    = 3'd0;
  localparam logic [2:0] STEP_SKIP1     = 3'd1;
  localparam logic [2:0] STEP_CONVERT   = 3'd2;
  localparam logic [2:0] STEP_CONV_WAIT = 3'd3;
  localparam logic [2:0] STEP_RESET2    = 3'd4;
  localparam logic [2:0] STEP_SKIP2     = 3'd5;
  localparam logic [2:0] STEP_READ_CMD  = 3'd6;
  localparam logic [2:0] STEP_READ_DATA = 3'd7;

  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_PRES = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WRITE    = 4'd4,
    PH_CONV     = 4'd5,
    PH_READ     = 4'd6
  } phase_t;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_timeout_ticks;
    logic [15:0] reset_recover_ticks;
    logic [15:0] slot_ticks;
    logic [15:0] release_ticks;
    logic [15:0] sample_ticks;
    logic [19:0] convert_wait_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    reset_low_ticks:        16'd480,
    presence_timeout_ticks: 16'd300,
    reset_recover_ticks:    16'd240,
    slot_ticks:             16'd60,
    release_ticks:          16'd2,
    sample_ticks:           16'd12,
    convert_wait_ticks:     20'd750000
  };

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               no_presence;
    logic signed [15:0] temperature;
  } res_t;

  // byte sent on the wire in each write step
  function automatic logic [7:0] cmd_byte(input logic [2:0] ci);
    logic [7:0] b;
    case (ci)
      STEP_SKIP1:    b = CMD_SKIP_ROM;
      STEP_CONVERT:  b = CMD_CONVERT;
      STEP_SKIP2:    b = CMD_SKIP_ROM;
      STEP_READ_CMD: b = CMD_READ_SCRATCH;
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

  // phase entered when a sequence step begins
  function automatic phase_t start_phase(input logic [2:0] ci);
    phase_t p;
    case (ci)
      STEP_RESET1:    p = PH_RST_LOW;
      STEP_RESET2:    p = PH_RST_LOW;
      STEP_CONV_WAIT: p = PH_CONV;
      STEP_READ_DATA: p = PH_READ;
      default:        p = PH_WRITE;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/onewire_temperature_reader.sv @@
// top level of the one-wire temperature reader
//
// usage:
// - slave stream (s_*): one beat per time tick or start request; s_tuser
//   selects the kind (0 = tick, 1 = start a read), s_tdata[0] carries the
//   sampled level of the data line during that tick
// - master stream (m_*): exactly one beat per input beat, showing the state
//   after that input: line drive, busy, done pulse, no-presence flag and the
//   last temperature (signed, 1/16 degree)
// - config channel (cfg_*): writes one timing register per beat, index in
//   cfg_index, value in cfg_data; write only while the block is idle
// latency: a result beat is valid one cycle after its input beat is taken
// throughput: one beat per cycle; the whole step is one pass through the
//   sequencer logic into the output register
// stall: while a result waits in the output register and m_tready is low,
//   s_tready is low; with m_tready high, input beats flow every cycle
// reset: synchronous; sequencer goes idle, temperature reads zero, timing
//   registers return to their defaults, no beats are taken during reset
`default_nettype none

`include "onewire_temperature_reader_assert.svh"

module onewire_temperature_reader #(
  parameter int unsigned COUNTER_WIDTH = owtr_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,  // [0] line_sample, [7:1] zero
  input  wire logic                              s_tuser,  // [0] func
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [23:0]                            m_tdata,  // [0] drive_low, [1] busy_res,
                                                           // [2] done_res, [3] no_presence,
                                                           // [19:4] temperature, [23:20] zero
  // config writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [owtr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [owtr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  owtr_pkg::cfg_t cfg;
  owtr_pkg::res_t res_next;
  owtr_pkg::res_t res_q;
  logic           s_accept;
  logic           cfg_accept;

  // take a beat whenever the output register is free or being drained
  assign s_tready   = !rst && (!m_tvalid || m_tready);
  assign s_accept   = s_tvalid && s_tready;
  assign cfg_ready  = !rst;
  assign cfg_accept = cfg_valid && cfg_ready;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= owtr_pkg::CFG_RESET;
    end else if (cfg_accept) begin
      case (cfg_index)
        owtr_pkg::REG_RESET_LOW:        cfg.reset_low_ticks        <= cfg_data[15:0];
        owtr_pkg::REG_PRESENCE_TIMEOUT: cfg.presence_timeout_ticks <= cfg_data[15:0];
        owtr_pkg::REG_RESET_RECOVER:    cfg.reset_recover_ticks    <= cfg_data[15:0];
        owtr_pkg::REG_SLOT:             cfg.slot_ticks             <= cfg_data[15:0];
        owtr_pkg::REG_RELEASE:          cfg.release_ticks          <= cfg_data[15:0];
        owtr_pkg::REG_SAMPLE:           cfg.sample_ticks           <= cfg_data[15:0];
        owtr_pkg::REG_CONVERT_WAIT:     cfg.convert_wait_ticks     <= cfg_data;
        default: begin
          // writes past the register list are dropped
        end
      endcase
    end
  end

  // sequencer: state advances once per accepted beat
  owtr_ctrl #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .advance     (s_accept),
    .func        (s_tuser),
    .line_sample (s_tdata[0]),
    .cfg         (cfg),
    .res_next    (res_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      res_q <= res_next;
    end
  end

  assign m_tdata = {4'b0000, res_q.temperature, res_q.no_presence, res_q.done_res,
                    res_q.busy_res, res_q.drive_low};

  // every accepted beat shows up as a result beat in the next cycle
  `OWTR_ASSERT_NXT(a_beat_follows, clk, rst, s_accept, m_tvalid)
  // a completed read is never flagged as missing presence and ends the sequence
  `OWTR_ASSERT_IMP(a_done_clean, clk, rst, m_tvalid && res_q.done_res, !res_q.no_presence && !res_q.busy_res)
  // the line is released whenever no sequence runs
  `OWTR_ASSERT_IMP(a_idle_released, clk, rst, m_tvalid && !res_q.busy_res, !res_q.drive_low)

endmodule

`default_nettype wire

@@ rtl/core/owtr_ctrl.sv @@
// bus sequencer: phase, tick counter, bit shifter and next result beat
`default_nettype none

module owtr_ctrl #(
  parameter int unsigned COUNTER_WIDTH = owtr_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic          func,
  input  wire logic          line_sample,
  input  wire owtr_pkg::cfg_t cfg,
  output owtr_pkg::res_t     res_next
);

  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

  owtr_pkg::phase_t          phase, phase_next;
  logic [COUNTER_WIDTH-1:0]  tick_count, tick_count_next;
  logic [3:0]                bit_index, bit_index_next;
  logic [2:0]                command_index, command_index_next;
  logic [15:0]               shift_data, shift_data_next;
  logic [15:0]               last_temperature, last_temperature_next;
  logic                      error_flag, error_flag_next;
  logic                      done_next;

  logic [COUNTER_WIDTH-1:0]  cnt_inc;
  logic [COUNTER_WIDTH-1:0]  lim_rst_low, lim_pres, lim_rec, lim_slot, lim_conv;
  logic [31:0]               slot32, sample32, sample_pt;
  logic                      start_en;
  logic [2:0]                start_ci;
  logic [7:0]                wr_byte;
  logic [32:0]               tick33, rel33, slot_raw33;
  logic                      drive;

  // clamp a limit to the counter range
  function automatic logic [COUNTER_WIDTH-1:0] sat_lim(input logic [19:0] v);
    if (32'(v) > 32'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return COUNTER_WIDTH'(v);
  endfunction

  assign cnt_inc     = (tick_count == CNT_MAX) ? tick_count : tick_count + 1'b1;
  assign lim_rst_low = sat_lim(20'(cfg.reset_low_ticks));
  assign lim_pres    = sat_lim(20'(cfg.presence_timeout_ticks));
  assign lim_rec     = sat_lim(20'(cfg.reset_recover_ticks));
  assign lim_slot    = sat_lim(20'(cfg.slot_ticks));
  assign lim_conv    = sat_lim(cfg.convert_wait_ticks);

  // sample point, pulled back to the last tick of the slot when it lies at or past the slot end
  assign slot32   = 32'(lim_slot);
  assign sample32 = 32'(cfg.sample_ticks);
  assign sample_pt = (sample32 >= slot32) ? ((slot32 != 32'd0) ? slot32 - 32'd1 : 32'd0)
                                          : sample32;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= owtr_pkg::PH_IDLE;
      tick_count       <= '0;
      bit_index        <= '0;
      command_index    <= '0;
      shift_data       <= '0;
      last_temperature <= '0;
      error_flag       <= 1'b0;
    end else if (advance) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_index        <= bit_index_next;
      command_index    <= command_index_next;
      shift_data       <= shift_data_next;
      last_temperature <= last_temperature_next;
      error_flag       <= error_flag_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    bit_index_next        = bit_index;
    command_index_next    = command_index;
    shift_data_next       = shift_data;
    last_temperature_next = last_temperature;
    error_flag_next       = error_flag;
    done_next             = 1'b0;
    start_en              = 1'b0;
    start_ci              = owtr_pkg::STEP_RESET1;

    if (phase != owtr_pkg::PH_IDLE) begin
      tick_count_next = cnt_inc;
    end

    case (phase)
      owtr_pkg::PH_IDLE: begin
        if (func == owtr_pkg::FUNC_START) begin
          error_flag_next = 1'b0;
          start_en        = 1'b1;
          start_ci        = owtr_pkg::STEP_RESET1;
        end
      end
      owtr_pkg::PH_RST_LOW: begin
        if (cnt_inc >= lim_rst_low) begin
          phase_next      = owtr_pkg::PH_RST_PRES;
          tick_count_next = '0;
        end
      end
      owtr_pkg::PH_RST_PRES: begin
        if (!line_sample) begin
          phase_next      = owtr_pkg::PH_RST_REC;
          tick_count_next = '0;
        end else if (cnt_inc >= lim_pres) begin
          error_flag_next = 1'b1;
          phase_next      = owtr_pkg::PH_IDLE;
          tick_count_next = '0;
        end
      end
      owtr_pkg::PH_RST_REC: begin
        if (cnt_inc >= lim_rec) begin
          start_en = 1'b1;
          start_ci = command_index + 3'd1;
        end
      end
      owtr_pkg::PH_CONV: begin
        if (cnt_inc >= lim_conv) begin
          start_en = 1'b1;
          start_ci = owtr_pkg::STEP_RESET2;
        end
      end
      owtr_pkg::PH_WRITE: begin
        if (cnt_inc >= lim_slot) begin
          tick_count_next = '0;
          if (bit_index[2:0] == 3'd7) begin
            start_en = 1'b1;
            start_ci = command_index + 3'd1;
          end else begin
            bit_index_next = bit_index + 4'd1;
          end
        end
      end
      owtr_pkg::PH_READ: begin
        if (32'(tick_count) == sample_pt) begin
          shift_data_next[bit_index] = line_sample;
        end
        if (cnt_inc >= lim_slot) begin
          tick_count_next = '0;
          if (bit_index == 4'd15) begin
            last_temperature_next = shift_data_next;
            phase_next            = owtr_pkg::PH_IDLE;
            bit_index_next        = '0;
            command_index_next    = '0;
            done_next             = 1'b1;
          end else begin
            bit_index_next = bit_index + 4'd1;
          end
        end
      end
      default: begin
        // unused phase codes act exactly like idle
        phase_next      = owtr_pkg::PH_IDLE;
        tick_count_next = tick_count;
        if (func == owtr_pkg::FUNC_START) begin
          error_flag_next = 1'b0;
          start_en        = 1'b1;
          start_ci        = owtr_pkg::STEP_RESET1;
        end
      end
    endcase

    if (start_en) begin
      command_index_next = start_ci;
      tick_count_next    = '0;
      bit_index_next     = '0;
      phase_next         = owtr_pkg::start_phase(start_ci);
      if (start_ci == owtr_pkg::STEP_READ_DATA) begin
        shift_data_next = '0;
      end
    end
  end

  // line drive for the state after this beat
  assign wr_byte    = owtr_pkg::cmd_byte(command_index_next);
  assign tick33     = 33'(tick_count_next);
  assign rel33      = 33'(cfg.release_ticks);
  assign slot_raw33 = 33'(cfg.slot_ticks);

  always_comb begin
    case (phase_next)
      owtr_pkg::PH_RST_LOW: drive = 1'b1;
      owtr_pkg::PH_WRITE:   drive = (tick33 < rel33) ||
                                    (!wr_byte[bit_index_next[2:0]] &&
                                     (tick33 + 33'd1 < slot_raw33));
      owtr_pkg::PH_READ:    drive = (tick33 < rel33);
      default:              drive = 1'b0;
    endcase
  end

  assign res_next.drive_low   = drive;
  assign res_next.busy_res    = (phase_next != owtr_pkg::PH_IDLE);
  assign res_next.done_res    = done_next;
  assign res_next.no_presence = error_flag_next;
  assign res_next.temperature = last_temperature_next;

endmodule

`default_nettype wire

@@ tb/sv/onewire_temperature_reader_checker.sv @@
// checker for the one-wire temperature reader: predicts every result beat and compares
module onewire_temperature_reader_checker
  import owtr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [7:0]             s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [23:0]            m_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     failures,
  output int                     pending,
  output int                     reads_done,
  output int                     presence_misses,
  output int                     reg_writes,
  output phase_t                 seq_phase,
  output logic [3:0]             seq_bit
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COUNTER_WIDTH_DEF;
  localparam int PRINT_CAP = 30;

  // byte put on the wire in each sequence step, step 7 leftmost
  localparam logic [7:0][7:0] WIRE_BYTES = {8'h00, CMD_READ_SCRATCH, CMD_SKIP_ROM, 8'h00,
                                            8'h00, CMD_CONVERT, CMD_SKIP_ROM, 8'h00};

  cfg_t          timing;
  logic [CW-1:0] ticks;
  logic [2:0]    step;
  logic [15:0]   shift;
  logic [15:0]   reading;
  logic          lost;
  res_t          expected_readouts[$];
  int            readouts_seen;

  initial begin
    failures = 0;
    pending = 0;
    reads_done = 0;
    presence_misses = 0;
    reg_writes = 0;
    readouts_seen = 0;
  end

  task automatic report_mismatch(string what, int want, int got);
    if (failures < PRINT_CAP)
      $display("[%0t] result %0d: %s expected %0d, got %0d", $time, readouts_seen, what,
               want, got);
    failures++;
  endtask

  task automatic enter_step(logic [2:0] s);
    step = s;
    ticks = '0;
    seq_bit = '0;
    case (s)
      STEP_RESET1, STEP_RESET2: seq_phase = PH_RST_LOW;
      STEP_CONV_WAIT: seq_phase = PH_CONV;
      STEP_READ_DATA: begin
        seq_phase = PH_READ;
        shift = '0;
      end
      default: seq_phase = PH_WRITE;
    endcase
  endtask

  // one tick or request through the sequencer, queues the result it shows
  task automatic sensor_read_step(logic func, logic line);
    logic [CW-1:0] prior;
    logic [CW-1:0] nxt;
    logic [CW:0]   sample_at;
    logic [CW:0]   slot;
    logic          done;
    res_t          r;
    prior = ticks;
    nxt = (&prior) ? prior : prior + 1'b1;
    slot = timing.slot_ticks;
    done = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (func == FUNC_START) begin
        lost = 1'b0;
        enter_step(STEP_RESET1);
      end
    end else begin
      ticks = nxt;
      case (seq_phase)
        PH_RST_LOW: if (nxt >= timing.reset_low_ticks) begin
          seq_phase = PH_RST_PRES;
          ticks = '0;
        end
        PH_RST_PRES: if (!line) begin
          seq_phase = PH_RST_REC;
          ticks = '0;
        end else if (nxt >= timing.presence_timeout_ticks) begin
          // nobody answered the reset, give up and flag it
          lost = 1'b1;
          seq_phase = PH_IDLE;
          ticks = '0;
          presence_misses++;
        end
        PH_RST_REC: if (nxt >= timing.reset_recover_ticks) enter_step(step + 3'd1);
        PH_CONV: if (nxt >= timing.convert_wait_ticks) enter_step(STEP_RESET2);
        PH_WRITE: if (nxt >= slot) begin
          ticks = '0;
          if (seq_bit[2:0] == 3'd7) enter_step(step + 3'd1);
          else seq_bit = seq_bit + 4'd1;
        end
        default: begin
          // sample point saturates to the last tick of the slot
          sample_at = timing.sample_ticks;
          if (sample_at >= slot) sample_at = (slot == 0) ? '0 : slot - 1'b1;
          if (prior == sample_at) shift[seq_bit] = line;
          if (nxt >= slot) begin
            ticks = '0;
            if (seq_bit == 4'd15) begin
              reading = shift;
              seq_phase = PH_IDLE;
              seq_bit = '0;
              step = STEP_RESET1;
              done = 1'b1;
              reads_done++;
            end else begin
              seq_bit = seq_bit + 4'd1;
            end
          end
        end
      endcase
    end
    case (seq_phase)
      PH_RST_LOW: r.drive_low = 1'b1;
      PH_WRITE: r.drive_low = (ticks < timing.release_ticks) ||
                              (!WIRE_BYTES[step][seq_bit[2:0]] && ({1'b0, ticks} + 1'b1 < slot));
      PH_READ: r.drive_low = ticks < timing.release_ticks;
      default: r.drive_low = 1'b0;
    endcase
    r.busy_res = seq_phase != PH_IDLE;
    r.done_res = done;
    r.no_presence = lost;
    r.temperature = reading;
    expected_readouts.push_back(r);
  endtask

  task automatic check_readout(logic [23:0] beat);
    res_t want;
    readouts_seen++;
    if (expected_readouts.size() == 0) begin
      report_mismatch("beat with nothing outstanding, tdata", 0, int'(beat));
    end else begin
      want = expected_readouts.pop_front();
      if (beat[0] !== want.drive_low) report_mismatch("drive_low", want.drive_low, beat[0]);
      if (beat[1] !== want.busy_res) report_mismatch("busy_res", want.busy_res, beat[1]);
      if (beat[2] !== want.done_res) report_mismatch("done_res", want.done_res, beat[2]);
      if (beat[3] !== want.no_presence)
        report_mismatch("no_presence", want.no_presence, beat[3]);
      if (beat[19:4] !== want.temperature)
        report_mismatch("temperature", int'(want.temperature), int'($signed(beat[19:4])));
    end
  endtask

  task automatic store_timing(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_RESET_LOW:        timing.reset_low_ticks = value[15:0];
      REG_PRESENCE_TIMEOUT: timing.presence_timeout_ticks = value[15:0];
      REG_RESET_RECOVER:    timing.reset_recover_ticks = value[15:0];
      REG_SLOT:             timing.slot_ticks = value[15:0];
      REG_RELEASE:          timing.release_ticks = value[15:0];
      REG_SAMPLE:           timing.sample_ticks = value[15:0];
      REG_CONVERT_WAIT:     timing.convert_wait_ticks = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  // results leave before new beats enter, so a same-edge pair never races;
  // a register write lands after the beat taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      timing = CFG_RESET;
      seq_phase = PH_IDLE;
      ticks = '0;
      seq_bit = '0;
      step = STEP_RESET1;
      shift = '0;
      reading = '0;
      lost = 1'b0;
      expected_readouts.delete();
    end else begin
      if (m_tvalid && m_tready) check_readout(m_tdata);
      if (s_tvalid && s_tready) sensor_read_step(s_tuser, s_tdata[0]);
      if (cfg_valid && cfg_ready) store_timing(cfg_index, cfg_data);
    end
    pending = expected_readouts.size();
  end

endmodule

@@ tb/sv/onewire_temperature_reader_test.sv @@
// top of the one-wire temperature reader testbench: stimulus, reset and verdict
module onewire_temperature_reader_test;
  timeunit 1ns;
  timeprecision 1ps;
  import owtr_pkg::*;

  // random beats after the directed part
  localparam int RANDOM_BEATS = 200;
  localparam int STALL_LIMIT = 2000;

  // how the line answers during one read sequence
  typedef enum {
    SEQ_PROMPT,   // presence on the first wait tick
    SEQ_LATE,     // presence after a random delay, may time out
    SEQ_ABSENT,   // line stays high, sequence ends with no presence
    SEQ_NOISE     // random line everywhere, stray requests while busy
  } read_kind_e;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;   // [0] line_sample, [7:1] zero
  logic                   s_tuser;   // [0] func
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [23:0]            m_tdata;   // [0] drive_low, [1] busy_res, [2] done_res,
                                     // [3] no_presence, [19:4] temperature, [23:20] zero
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int         mismatches;
  int         pending;
  int         reads_done;
  int         presence_misses;
  int         reg_writes;
  phase_t     seq_phase;
  logic [3:0] seq_bit;

  int beats = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  onewire_temperature_reader DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  onewire_temperature_reader_checker readout_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .failures        (mismatches),
    .pending         (pending),
    .reads_done      (reads_done),
    .presence_misses (presence_misses),
    .reg_writes      (reg_writes),
    .seq_phase       (seq_phase),
    .seq_bit         (seq_bit)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: switches between always ready, sparse stalls, periodic stalls and heavy stalls
  int rx_left = 0;
  int rx_mode = 0;
  int rx_count = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    rx_count++;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 5) != 0;
      2: m_tready <= (rx_count % 4) != 0;
      default: m_tready <= $urandom_range(0, 1);
    endcase
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding", STALL_LIMIT,
               pending);
      $display("tb: failure");
      $finish;
    end
  end

  // one input beat; called at a falling edge, returns at the falling edge after acceptance
  task automatic send(logic func, logic line);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
    end
    burst_left--;
    s_tuser = func;
    s_tdata = {7'd0, line};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    beats++;
  endtask

  // sender holds off until every result it caused has come back
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // timing writes only land with the sequencer idle and nothing in flight
  task automatic load_timings(cfg_t t);
    while (seq_phase != PH_IDLE) send(FUNC_TICK, $urandom_range(0, 1));
    drain();
    write_reg(REG_RESET_LOW, t.reset_low_ticks);
    write_reg(REG_PRESENCE_TIMEOUT, t.presence_timeout_ticks);
    write_reg(REG_RESET_RECOVER, t.reset_recover_ticks);
    write_reg(REG_SLOT, t.slot_ticks);
    write_reg(REG_RELEASE, t.release_ticks);
    write_reg(REG_SAMPLE, t.sample_ticks);
    write_reg(REG_CONVERT_WAIT, t.convert_wait_ticks);
  endtask

  // short timings, in ticks, keep each full read short
  function automatic cfg_t random_timings();
    cfg_t t;
    t.reset_low_ticks = $urandom_range(1, 4);
    t.presence_timeout_ticks = $urandom_range(2, 6);
    t.reset_recover_ticks = $urandom_range(1, 3);
    t.slot_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    t.release_ticks = $urandom_range(1, 5);
    t.sample_ticks = $urandom_range(1, 8);
    t.convert_wait_ticks = $urandom_range(1, 6);
    return t;
  endfunction

  // line level for the next tick, from the sequencer state the checker tracks
  function automatic logic line_level(read_kind_e kind, logic [15:0] target);
    logic level;
    level = $urandom_range(0, 1);
    if (kind != SEQ_NOISE) begin
      if (seq_phase == PH_RST_PRES) begin
        case (kind)
          SEQ_PROMPT: level = 1'b0;
          SEQ_LATE: level = $urandom_range(0, 2) != 0;
          default: level = 1'b1;
        endcase
      end else if (seq_phase == PH_READ) begin
        // hold the wanted bit through the whole slot, the sample lands somewhere in it
        level = target[seq_bit];
      end
    end
    return level;
  endfunction

  // a start request, then ticks until the sequencer is idle again
  task automatic run_read(read_kind_e kind, logic [15:0] target);
    logic func;
    send(FUNC_START, $urandom_range(0, 1));
    while (seq_phase != PH_IDLE) begin
      func = FUNC_TICK;
      // a request while busy must act as a plain tick
      if (kind == SEQ_NOISE && $urandom_range(0, 7) == 0) func = FUNC_START;
      if ($urandom_range(0, 199) == 0) drain();
      send(func, line_level(kind, target));
    end
  endtask

  function automatic read_kind_e random_kind();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return SEQ_PROMPT;
    if (roll < 8) return SEQ_LATE;
    if (roll < 9) return SEQ_ABSENT;
    return SEQ_NOISE;
  endfunction

  function automatic logic [15:0] random_reading();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    cfg_t ones;
    cfg_t saturate;
    int   random_start;
    int   phase_end;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_TICK;
    cfg_valid = 1'b0;
    cfg_index = REG_RESET_LOW;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset timings: a reset pulse and a full presence wait with nobody answering
    send(FUNC_TICK, 1'b0);
    run_read(SEQ_ABSENT, 16'h0000);

    // every timing at its minimum: one-tick slots, always low at slot start
    ones = '{reset_low_ticks: 16'd1, presence_timeout_ticks: 16'd1,
             reset_recover_ticks: 16'd1, slot_ticks: 16'd1, release_ticks: 16'd1,
             sample_ticks: 16'd1, convert_wait_ticks: 20'd1};
    load_timings(ones);
    run_read(SEQ_PROMPT, 16'h7FFF);
    run_read(SEQ_PROMPT, 16'h8000);
    run_read(SEQ_ABSENT, 16'h0000);
    run_read(SEQ_PROMPT, 16'hFFFF);
    run_read(SEQ_NOISE, 16'h0000);
    run_read(SEQ_PROMPT, 16'h0000);

    // release and sample past the slot end, long presence window
    saturate = '{reset_low_ticks: 16'd1, presence_timeout_ticks: 16'hFFFF,
                 reset_recover_ticks: 16'd1, slot_ticks: 16'd4, release_ticks: 16'hFFFF,
                 sample_ticks: 16'hFFFF, convert_wait_ticks: 20'd1};
    load_timings(saturate);
    run_read(SEQ_LATE, 16'hA5C3);

    // random part: several short timing sets, each with a run of reads
    random_start = beats;
    while (beats - random_start < RANDOM_BEATS) begin
      load_timings(random_timings());
      phase_end = beats + $urandom_range(120, 260);
      while (beats < phase_end) begin
        repeat ($urandom_range(0, 2)) send(FUNC_TICK, $urandom_range(0, 1));
        run_read(random_kind(), random_reading());
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d input beats over %0d timing register writes", beats, reg_writes);
    $display("%0d readings finished, %0d sequences ended without presence", reads_done,
             presence_misses);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
